// ===== design/pss_pkg.sv =====
// Shared types and codes for the packed string slot store.
// Used by the controller, the datapath and the top level; depends on nothing.
package pss_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_EMPTY  = 2'd1;
    localparam t_status ST_BEYOND = 2'd2;
    localparam t_status ST_DROP   = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic    latch;
        logic    set_status;
        t_status status;
        logic    rd_issue;
        logic    rd_capture;
        logic    close_run;
        logic    open_run;
        logic    mv_init;
        logic    mv_wr;
        logic    rm_fin;
        logic    open_slot;
        logic    app_data;
        logic    app_term;
        logic    load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_write;
        logic slot_oob;
        logic slot_valid;
        logic new_run;
        logic off_beyond;
        logic pos_beyond;
        logic room;
        logic used_nz;
        logic mv_done;
    } t_sts;

endpackage

// ===== design/packed_string_slot_store.sv =====
// Packed string slot store: one transaction is in work at a time. After S_DECODE a read
// passes S_RD_WAIT; an append passes S_APP_CHK and S_APP_TERM, after S_OPEN on an empty slot
// and, on a replacement, after S_MV_RD and S_MV_WR move each later byte over the one RAM
// port, then S_RM_FIN and S_OPEN. Empty, beyond and dropped items skip ahead to S_FIN. The
// next transaction is taken the cycle after the result loads; a result not yet taken holds
// back the next load. Synchronous reset empties all slots and the fill count.
module packed_string_slot_store #(
    parameter int SLOT_COUNT   = 32,
    parameter int BUFFER_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [4:0]  i_slot,
    input  logic [9:0]  i_offset,
    input  logic [7:0]  i_data,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_byte,
    output logic [1:0]  o_status,
    output logic [10:0] o_used_bytes
);
    pss_pkg::t_cmd cmd;
    pss_pkg::t_sts sts;

    pss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pss_dp #(
        .SLOT_COUNT   (SLOT_COUNT),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_action     (i_action),
        .i_slot       (i_slot),
        .i_offset     (i_offset),
        .i_data       (i_data),
        .i_last       (i_last),
        .o_read_byte  (o_read_byte),
        .o_status     (o_status),
        .o_used_bytes (o_used_bytes)
    );
endmodule

// ===== design/pss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/pss_dp.sv =====
// Datapath: character buffer, slot tables, fill count, move pointers, result register.
// Depends on pss_pkg and pss_ram.
module pss_dp #(
    parameter int SLOT_COUNT   = 32,
    parameter int BUFFER_BYTES = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pss_pkg::t_cmd  i_cmd,
    output pss_pkg::t_sts  o_sts,
    input  logic           i_action,
    input  logic [4:0]     i_slot,
    input  logic [9:0]     i_offset,
    input  logic [7:0]     i_data,
    input  logic           i_last,
    output logic [7:0]     o_read_byte,
    output logic [1:0]     o_status,
    output logic [10:0]    o_used_bytes
);
    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int SW = $clog2(SLOT_COUNT);
    localparam int PW = ((AW > 10) ? AW : 10) + 1;

    logic          r_action;
    logic [4:0]    r_slot;
    logic [9:0]    r_offset;
    logic [7:0]    r_data;
    logic          r_last;
    logic [7:0]    r_byte;
    pss_pkg::t_status r_status;

    logic [AW-1:0] r_start [SLOT_COUNT];
    logic [CW-1:0] r_len   [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_valid;
    logic [CW-1:0] r_used;
    logic          r_open;
    logic [4:0]    r_wslot;

    logic [CW-1:0] r_src;
    logic [AW-1:0] r_dst;
    logic [CW-1:0] r_mv_cnt;

    logic [7:0]    r_out_byte;
    logic [1:0]    r_out_status;
    logic [10:0]   r_out_used;

    logic [SW-1:0] sidx;
    logic [AW-1:0] cur_start;
    logic [CW-1:0] cur_len;
    logic [PW-1:0] pos;
    logic [CW-1:0] tail;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    assign sidx      = SW'(r_slot);
    assign cur_start = r_start[sidx];
    assign cur_len   = r_len[sidx];
    assign pos       = PW'(cur_start) + PW'(r_offset);
    assign tail      = CW'(cur_start) + cur_len;

    always_comb begin
        o_sts.is_write   = r_action;
        o_sts.slot_oob   = (32'(r_slot) >= SLOT_COUNT);
        o_sts.slot_valid = r_valid[sidx];
        o_sts.new_run    = !r_open || (r_wslot != r_slot);
        o_sts.off_beyond = PW'(r_offset) >= PW'(cur_len);
        o_sts.pos_beyond = pos >= PW'(BUFFER_BYTES);
        o_sts.room       = r_used < CW'(BUFFER_BYTES);
        o_sts.used_nz    = r_used != '0;
        o_sts.mv_done    = r_mv_cnt == '0;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(r_used);
        ram_wdata = 8'd0;
        if (i_cmd.mv_wr) begin
            ram_we    = 1'b1;
            ram_waddr = r_dst;
            ram_wdata = ram_rdata;
        end else if (i_cmd.open_slot || i_cmd.app_term) begin
            ram_we    = 1'b1;
        end else if (i_cmd.app_data) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(r_used - CW'(1));
            ram_wdata = r_data;
        end
        ram_raddr = i_cmd.rd_issue ? AW'(pos) : AW'(r_src);
    end

    pss_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state: slot occupancy, lengths, fill count, open run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_len[i] <= '0;
            end
            r_used  <= '0;
            r_open  <= 1'b0;
            r_wslot <= '0;
        end else begin
            if (i_cmd.close_run) begin
                r_open <= 1'b0;
            end
            if (i_cmd.open_run) begin
                r_open  <= 1'b1;
                r_wslot <= r_slot;
            end
            if (i_cmd.rm_fin) begin
                r_used <= (cur_len <= r_used) ? r_used - cur_len : '0;
                r_valid[sidx] <= 1'b0;
                r_len[sidx]   <= '0;
            end
            if (i_cmd.open_slot) begin
                r_used <= r_used + CW'(1);
                r_len[sidx]   <= CW'(1);
                r_valid[sidx] <= 1'b1;
            end
            if (i_cmd.app_term) begin
                r_used <= r_used + CW'(1);
                r_len[sidx] <= cur_len + CW'(1);
            end
            if (i_cmd.load_out && r_action && r_last) begin
                r_open <= 1'b0;
            end
        end
    end

    // payload: latched item, slot starts, move pointers, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= i_action;
            r_slot   <= i_slot;
            r_offset <= i_offset;
            r_data   <= i_data;
            r_last   <= i_last;
            r_status <= pss_pkg::ST_OK;
            r_byte   <= 8'd0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.rd_capture) begin
            r_byte <= ram_rdata;
        end
        if (i_cmd.mv_init) begin
            r_src    <= tail;
            r_dst    <= cur_start;
            r_mv_cnt <= (tail <= r_used) ? r_used - tail : '0;
        end
        if (i_cmd.mv_wr) begin
            r_src    <= r_src + CW'(1);
            r_dst    <= r_dst + AW'(1);
            r_mv_cnt <= r_mv_cnt - CW'(1);
        end
        if (i_cmd.rm_fin) begin
            // pull back every later string by the removed size
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (r_valid[i] && (SW'(i) != sidx) && (r_start[i] > cur_start)) begin
                    r_start[i] <= r_start[i] - AW'(cur_len);
                end
            end
        end
        if (i_cmd.open_slot) begin
            r_start[sidx] <= AW'(r_used);
        end
        if (i_cmd.load_out) begin
            r_out_byte   <= r_byte;
            r_out_status <= r_status;
            r_out_used   <= 11'(r_used);
        end
    end

    assign o_read_byte  = r_out_byte;
    assign o_status     = r_out_status;
    assign o_used_bytes = r_out_used;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(BUFFER_BYTES))
        else $error("fill count beyond buffer size");

    a_mv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mv_wr |=> r_mv_cnt == $past(r_mv_cnt) - CW'(1))
        else $error("move count did not step");

    a_append_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.app_term |=> r_used == $past(r_used) + CW'(1))
        else $error("append did not grow fill count");
endmodule

// ===== design/pss_ctrl.sv =====
// Controller state machine: sequences reads, removal moves and appends.
// Depends on pss_pkg.
module pss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  pss_pkg::t_sts i_sts,
    output pss_pkg::t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_MV_RD,
        S_MV_WR,
        S_RM_FIN,
        S_OPEN,
        S_APP_CHK,
        S_APP_TERM,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.is_write) begin
                    if (i_sts.slot_oob || !i_sts.slot_valid) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = pss_pkg::ST_EMPTY;
                        n_state          = S_FIN;
                    end else if (i_sts.off_beyond) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = pss_pkg::ST_BEYOND;
                        n_state          = S_FIN;
                    end else if (i_sts.pos_beyond) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = S_RD_WAIT;
                    end
                end else if (i_sts.slot_oob) begin
                    o_cmd.close_run  = 1'b1;
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = pss_pkg::ST_DROP;
                    n_state          = S_FIN;
                end else if (i_sts.new_run) begin
                    o_cmd.open_run = 1'b1;
                    if (i_sts.slot_valid) begin
                        o_cmd.mv_init = 1'b1;
                        n_state       = S_MV_RD;
                    end else begin
                        n_state = S_OPEN;
                    end
                end else begin
                    n_state = S_APP_CHK;
                end
            end
            S_RD_WAIT: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_FIN;
            end
            S_MV_RD: begin
                n_state = i_sts.mv_done ? S_RM_FIN : S_MV_WR;
            end
            S_MV_WR: begin
                o_cmd.mv_wr = 1'b1;
                n_state     = S_MV_RD;
            end
            S_RM_FIN: begin
                o_cmd.rm_fin = 1'b1;
                n_state      = S_OPEN;
            end
            S_OPEN: begin
                o_cmd.open_slot = i_sts.room;
                n_state         = S_APP_CHK;
            end
            S_APP_CHK: begin
                if (i_sts.slot_valid && i_sts.room && i_sts.used_nz) begin
                    o_cmd.app_data = 1'b1;
                    n_state        = S_APP_TERM;
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = pss_pkg::ST_DROP;
                    n_state          = S_FIN;
                end
            end
            S_APP_TERM: begin
                o_cmd.app_term = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !i_out_ready) |=> r_state == S_FIN)
        else $error("result loaded over a pending one");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result dropped");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == S_DECODE)
        else $error("accepted transaction not decoded");
endmodule

// ===== test/packed_string_slot_store_tb.sv =====
// Testbench for packed_string_slot_store: directed table then random write runs and reads,
// each result checked against an in-bench string buffer model. Depends on pss_pkg and the DUT.
`timescale 1ns / 1ps

module packed_string_slot_store_tb;

    localparam int NSLOT = 32;
    localparam int NBUF  = 1024;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic       action;
        logic [4:0] slot;
        logic [9:0] offset;
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [7:0]       rbyte;
        pss_pkg::t_status status;
        logic [10:0]      used;
    } t_res;

    // directed row: item, whether an expectation is typed in, and the typed result
    typedef struct packed {
        t_item item;
        logic  fixed;
        t_res  res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_action = 1'b0;
    logic [4:0]  i_slot = '0;
    logic [9:0]  i_offset = '0;
    logic [7:0]  i_data = '0;
    logic        i_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_read_byte;
    logic [1:0]  o_status;
    logic [10:0] o_used_bytes;

    packed_string_slot_store u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model state
    logic [7:0]  buf_mem [NBUF];
    logic [9:0]  str_start [NSLOT];
    logic        str_valid [NSLOT];
    logic [10:0] str_len [NSLOT];
    int          used_cnt;
    logic        run_open;
    logic [4:0]  run_slot;

    t_res pending_q [$];
    int   errors = 0;
    int   results_seen = 0;
    int   drop_seen = 0;
    int   replace_seen = 0;
    bit   hold_off = 1'b0;
    bit   hold_req = 1'b0;
    bit   offering = 1'b0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("MISMATCH %s at result %0d: got %0d expected %0d", what, results_seen, got, exp);
        errors++;
    endtask

    function automatic void model_reset();
        for (int i = 0; i < NBUF; i++) buf_mem[i] = '0;
        for (int i = 0; i < NSLOT; i++) begin
            str_start[i] = '0;
            str_valid[i] = 1'b0;
            str_len[i] = '0;
        end
        used_cnt = 0;
        run_open = 1'b0;
        run_slot = '0;
    endfunction

    function automatic void drop_string(input int s);
        int b;
        int n;
        b = str_start[s];
        n = str_len[s];
        if (b + n <= used_cnt)
            for (int i = b; i < used_cnt - n; i++) buf_mem[i] = buf_mem[i + n];
        for (int i = 0; i < NSLOT; i++)
            if (str_valid[i] && i != s && str_start[i] > b) str_start[i] -= n;
        used_cnt = (n <= used_cnt) ? used_cnt - n : 0;
        str_valid[s] = 1'b0;
        str_len[s] = '0;
    endfunction

    function automatic t_res store_step(input t_item it);
        t_res r;
        int s;
        r = '{rbyte: 8'd0, status: pss_pkg::ST_OK, used: '0};
        s = it.slot;
        if (it.action == ACT_READ) begin
            if (!str_valid[s]) r.status = pss_pkg::ST_EMPTY;
            else if (it.offset >= str_len[s]) r.status = pss_pkg::ST_BEYOND;
            else if (str_start[s] + it.offset < NBUF) r.rbyte = buf_mem[str_start[s] + it.offset];
        end else begin
            if (!run_open || run_slot != it.slot) begin
                if (str_valid[s]) begin
                    drop_string(s);
                    replace_seen++;
                end
                run_slot = it.slot;
                run_open = 1'b1;
                if (used_cnt < NBUF) begin
                    str_start[s] = used_cnt[9:0];
                    buf_mem[used_cnt] = 8'd0;
                    used_cnt++;
                    str_len[s] = 11'd1;
                    str_valid[s] = 1'b1;
                end
            end
            if (str_valid[s] && used_cnt < NBUF && used_cnt > 0) begin
                buf_mem[used_cnt - 1] = it.data;
                buf_mem[used_cnt] = 8'd0;
                used_cnt++;
                str_len[s]++;
            end else begin
                r.status = pss_pkg::ST_DROP;
                drop_seen++;
            end
            if (it.last) run_open = 1'b0;
        end
        r.used = used_cnt[10:0];
        return r;
    endfunction

    // sender: bursts with gaps; valid drops only when a gap or a drain follows
    int burst_left = 0;

    task automatic send_item(input t_item it, input bit allow_gap);
        int gap;
        gap = 0;
        if (allow_gap) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
        end
        if (gap > 0) begin
            if (offering) begin
                i_in_valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= it.action;
        i_slot <= it.slot;
        i_offset <= it.offset;
        i_data <= it.data;
        i_last <= it.last;
        offering = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_item mk(input logic a, input int s, input int o, input int d,
                                 input logic l);
        t_item it;
        it = '{action: a, slot: s[4:0], offset: o[9:0], data: d[7:0], last: l};
        return it;
    endfunction

    // receiver: stalls on its own pattern, plus a long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else if (hold_off) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(0, 9) < 7) || (results_seen % 97 > 60);
    end

    initial begin : hold_proc
        wait (hold_req);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // result checker
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                report("result with none pending", 32'(o_used_bytes), 32'd0);
            end else begin
                e = pending_q.pop_front();
                if (o_read_byte !== e.rbyte)
                    report("read_byte", 32'(o_read_byte), 32'(e.rbyte));
                if (o_status !== e.status)
                    report("status", 32'(o_status), 32'(e.status));
                if (o_used_bytes !== e.used)
                    report("used_bytes", 32'(o_used_bytes), 32'(e.used));
            end
            results_seen++;
        end
    end

    t_row rows [] = '{
        '{mk(ACT_READ, 0, 0, 1, 0), 1'b1, '{8'd0, pss_pkg::ST_EMPTY, 11'd0}},
        '{mk(ACT_READ, 31, 1023, 255, 1), 1'b1, '{8'd0, pss_pkg::ST_EMPTY, 11'd0}},
        '{mk(ACT_WRITE, 0, 0, 8'h41, 0), 1'b1, '{8'd0, pss_pkg::ST_OK, 11'd2}},
        '{mk(ACT_READ, 0, 0, 0, 0), 1'b1, '{8'h41, pss_pkg::ST_OK, 11'd2}},
        '{mk(ACT_READ, 0, 1, 0, 0), 1'b1, '{8'd0, pss_pkg::ST_OK, 11'd2}},
        '{mk(ACT_READ, 0, 2, 0, 0), 1'b1, '{8'd0, pss_pkg::ST_BEYOND, 11'd2}},
        '{mk(ACT_WRITE, 0, 0, 8'hFF, 1), 1'b1, '{8'd0, pss_pkg::ST_OK, 11'd3}},
        '{mk(ACT_WRITE, 31, 1023, 8'h01, 0), 1'b0, '0},
        '{mk(ACT_WRITE, 31, 0, 8'h00, 0), 1'b0, '0},
        '{mk(ACT_WRITE, 31, 0, 8'h7E, 1), 1'b0, '0},
        '{mk(ACT_READ, 31, 1, 0, 0), 1'b0, '0},
        '{mk(ACT_WRITE, 5, 0, 8'h55, 0), 1'b0, '0},
        '{mk(ACT_READ, 5, 0, 0, 0), 1'b0, '0},
        '{mk(ACT_WRITE, 6, 0, 8'hAA, 1), 1'b0, '0},
        '{mk(ACT_WRITE, 0, 0, 8'h33, 0), 1'b0, '0},
        '{mk(ACT_WRITE, 0, 0, 8'h34, 1), 1'b0, '0},
        '{mk(ACT_READ, 31, 0, 0, 0), 1'b0, '0},
        '{mk(ACT_READ, 6, 0, 0, 0), 1'b0, '0},
        '{mk(ACT_READ, 5, 1023, 0, 0), 1'b0, '0},
        '{mk(ACT_READ, 0, 2, 0, 0), 1'b0, '0}
    };

    // one random write run with reads mixed in; slot choice is biased to hit replacements
    task automatic random_run(input int maxlen);
        int s;
        int n;
        s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7);
        n = $urandom_range(1, maxlen);
        for (int k = 0; k < n; k++) begin
            t_item it;
            it = mk(ACT_WRITE, s, $urandom_range(0, 1023), $urandom_range(0, 255), k == n - 1);
            if ($urandom_range(0, 30) == 0) it.last = 1'b1;
            pending_q.push_back(store_step(it));
            send_item(it, 1'b1);
            if ($urandom_range(0, 5) == 0) begin
                it = mk(ACT_READ, $urandom_range(0, 31), $urandom_range(0, 12),
                        $urandom_range(0, 255), 1'($urandom_range(0, 1)));
                pending_q.push_back(store_step(it));
                send_item(it, 1'b1);
            end
        end
    endtask

    task automatic random_read();
        t_item it;
        int s;
        s = $urandom_range(0, 31);
        it = mk(ACT_READ, s, 0, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
        it.offset = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                  : 10'($urandom_range(0, str_len[s] + 1));
        pending_q.push_back(store_step(it));
        send_item(it, 1'b1);
    endtask

    initial begin : stim
        int sent;
        model_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            t_res p;
            p = store_step(rows[i].item);
            if (rows[i].fixed && p !== rows[i].res)
                report($sformatf("directed row %0d", i), 32'(p), 32'(rows[i].res));
            pending_q.push_back(rows[i].fixed ? rows[i].res : p);
            send_item(rows[i].item, 1'b0);
        end
        drain();

        // long receiver hold while the sender keeps pushing
        hold_req = 1'b1;
        for (int k = 0; k < 12; k++) random_read();
        drain();

        sent = 32;
        while (sent < 600) begin
            int prev_total;
            prev_total = pending_q.size() + results_seen;
            if ($urandom_range(0, 2) == 0) random_read();
            else random_run(used_cnt > 900 ? 60 : 12);
            sent += pending_q.size() + results_seen - prev_total;
            if (sent % 150 < 5) drain();
        end
        drain();
        repeat (3000) @(posedge i_clk);
        $display("covered %0d results, %0d replacements, %0d dropped writes",
                 results_seen, replace_seen, drop_seen);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("packed_string_slot_store_tb passed");
        end else begin
            $display("packed_string_slot_store_tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #50ms;
        $display("packed_string_slot_store_tb failed");
        $finish;
    end

endmodule
